// ===== src/ces_pkg.sv =====
// Package for the coalescing extent set: default sizes, codes, controller states
// and the command/status words between controller and datapath. No dependencies.
package ces_pkg;

    localparam int ADDR_BITS_DEF   = 32;
    localparam int MAX_EXTENTS_DEF = 32;

    // Result field widths
    localparam int TOTAL_W = 33;
    localparam int EXT_W   = 6;
    localparam logic [TOTAL_W-1:0] TOTAL_SAT = {TOTAL_W{1'b1}};
    localparam logic [EXT_W-1:0]   EXT_SAT   = {EXT_W{1'b1}};

    // Operation codes
    localparam logic OP_SET   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN,
        S_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;    // latch a new word
        logic scan;    // examine one table entry
        logic finish;  // commit the operation
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic bad_range;  // incoming word has an invalid range
        logic last;       // entry under scan is the final one
    } t_stat;

endpackage

// ===== src/ces_ctrl.sv =====
// Controller for the coalescing extent set: load, scan the table, commit, report;
// an invalid range skips the scan and the commit. Depends on ces_pkg.
module ces_ctrl import ces_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_done
);

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.bad_range ? S_OUT : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== src/ces_datapath.sv =====
// Datapath for the coalescing extent set: bound memories, valid bits, counters,
// per-entry scan logic and commit. Depends on ces_pkg.
module ces_datapath import ces_pkg::*; #(
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic                 i_operation,
    input  logic [31:0]          i_range_start,
    input  logic [32:0]          i_range_length,
    output t_stat                o_stat,
    output logic [1:0]           o_status,
    output logic [TOTAL_W-1:0]   o_total_set,
    output logic [EXT_W-1:0]     o_extents_used,
    output logic                 o_is_empty
);

    localparam int AW  = ADDR_BITS;
    localparam int CW  = ADDR_BITS + 1;
    localparam int IW  = $clog2(MAX_EXTENTS);
    localparam int ECW = $clog2(MAX_EXTENTS + 1);
    localparam int SW  = (CW > TOTAL_W) ? CW : TOTAL_W;
    localparam int XW  = (ECW > EXT_W) ? ECW : EXT_W;
    localparam logic [63:0]    ADDR_MAX = (64'd1 << ADDR_BITS) - 64'd1;
    localparam logic [IW-1:0]  LAST_IDX = IW'(MAX_EXTENTS - 1);
    localparam logic [ECW-1:0] EXT_MAX  = ECW'(MAX_EXTENTS);

    // Extent bounds
    logic [AW-1:0] first_mem [MAX_EXTENTS];
    logic [AW-1:0] final_mem [MAX_EXTENTS];
    logic [AW-1:0] r_rd_first, r_rd_final;

    logic [MAX_EXTENTS-1:0] r_valid, r_pend;
    logic [CW-1:0]  r_count, r_msum;
    logic [ECW-1:0] r_ext, r_mcnt;
    logic [IW-1:0]  r_idx, r_slot;
    logic           r_slot_ok;
    logic           r_op;
    logic [AW-1:0]  r_lo, r_hi, r_nlo, r_nhi, r_tail;
    logic           r_noop, r_abort, r_split;
    logic [1:0]     r_status;

    // Range check of the incoming word
    logic [63:0] s64, last64;
    logic        bad;
    assign s64    = {32'd0, i_range_start};
    assign last64 = s64 + {31'd0, i_range_length} - 64'd1;
    assign bad    = (i_range_length == 33'd0) || (last64 > ADDR_MAX);

    assign o_stat.bad_range = bad;
    assign o_stat.last      = (r_idx == LAST_IDX);

    // Per-entry comparisons
    logic [AW-1:0] f, l, mx, mn;
    logic [AW:0]   l1, hi1;
    logic          pv, cov1, mrg, ovl, contain, cut_left, cut_right, table_full;
    logic [CW-1:0] elen, olen;
    always_comb begin
        f          = r_rd_first;
        l          = r_rd_final;
        pv         = r_valid[r_idx];
        l1         = {1'b0, l} + 1'b1;
        hi1        = {1'b0, r_hi} + 1'b1;
        cov1       = pv && (f <= r_lo) && (l >= r_hi);
        mrg        = pv && (l1 >= {1'b0, r_lo}) && ({1'b0, f} <= hi1);
        ovl        = pv && (l >= r_lo) && (f <= r_hi);
        contain    = ovl && (f < r_lo) && (l > r_hi);
        cut_left   = ovl && (f < r_lo);
        cut_right  = ovl && (l > r_hi);
        table_full = (r_ext == EXT_MAX);
        mx         = (f > r_lo) ? f : r_lo;
        mn         = (l < r_hi) ? l : r_hi;
        elen       = {1'b0, l} - {1'b0, f} + 1'b1;
        olen       = {1'b0, mn} - {1'b0, mx} + 1'b1;
    end

    // Commit decision for a set
    logic set_full, set_apply;
    assign set_full  = (r_mcnt == '0) && table_full;
    assign set_apply = !r_noop && !set_full;

    // Memory write port
    logic          we_first, we_final;
    logic [IW-1:0] waddr;
    logic [AW-1:0] wfirst, wfinal;
    always_comb begin
        we_first = 1'b0;
        we_final = 1'b0;
        waddr    = r_idx;
        wfirst   = r_hi + 1'b1;
        wfinal   = r_lo - 1'b1;
        if (i_cmd.scan && r_op == OP_CLEAR) begin
            we_final = cut_left && !(contain && table_full);
            we_first = cut_right && !contain;
        end else if (i_cmd.finish) begin
            waddr = r_slot;
            if (r_op == OP_SET) begin
                we_first = set_apply;
                we_final = set_apply;
                wfirst   = r_nlo;
                wfinal   = r_nhi;
            end else begin
                we_first = r_split;
                we_final = r_split;
                wfinal   = r_tail;
            end
        end
    end

    // Memories with registered read
    logic [IW-1:0] raddr;
    assign raddr = i_cmd.scan ? r_idx + 1'b1 : '0;
    always_ff @(posedge i_clk) begin
        if (we_first) begin
            first_mem[waddr] <= wfirst;
        end
        if (we_final) begin
            final_mem[waddr] <= wfinal;
        end
        r_rd_first <= first_mem[raddr];
        r_rd_final <= final_mem[raddr];
    end

    // Control state: valid bits and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_ext   <= '0;
        end else if (i_cmd.scan && r_op == OP_CLEAR && ovl) begin
            if (contain) begin
                if (!table_full) begin
                    r_count <= r_count - olen;
                end
            end else begin
                r_count <= r_count - olen;
                if (!cut_left && !cut_right) begin
                    r_valid[r_idx] <= 1'b0;
                    r_ext          <= r_ext - 1'b1;
                end
            end
        end else if (i_cmd.finish) begin
            if (r_op == OP_SET) begin
                if (set_apply) begin
                    // merged entries drop out, the joined extent takes the slot
                    r_valid <= (r_valid & ~r_pend) | (MAX_EXTENTS'(1) << r_slot);
                    r_count <= r_count - r_msum
                             + ({1'b0, r_nhi} - {1'b0, r_nlo} + 1'b1);
                    r_ext   <= r_ext - r_mcnt + 1'b1;
                end
            end else if (r_split) begin
                r_valid[r_slot] <= 1'b1;
                r_ext           <= r_ext + 1'b1;
            end
        end
    end

    // Operation registers: load, then accumulate over the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_lo      <= s64[AW-1:0];
            r_hi      <= last64[AW-1:0];
            r_nlo     <= s64[AW-1:0];
            r_nhi     <= last64[AW-1:0];
            r_idx     <= '0;
            r_pend    <= '0;
            r_msum    <= '0;
            r_mcnt    <= '0;
            r_slot    <= '0;
            r_slot_ok <= 1'b0;
            r_noop    <= 1'b0;
            r_abort   <= 1'b0;
            r_split   <= 1'b0;
            r_status  <= bad ? ST_BAD : ST_OK;
        end else if (i_cmd.scan) begin
            r_idx <= r_idx + 1'b1;
            // first free slot; for a set, a merged entry frees its slot too
            if (!r_slot_ok && (!pv || (r_op == OP_SET && mrg))) begin
                r_slot    <= r_idx;
                r_slot_ok <= 1'b1;
            end
            if (r_op == OP_SET) begin
                if (cov1) begin
                    r_noop <= 1'b1;
                end
                if (mrg) begin
                    r_pend[r_idx] <= 1'b1;
                    r_mcnt        <= r_mcnt + 1'b1;
                    r_msum        <= r_msum + elen;
                    if (f < r_nlo) begin
                        r_nlo <= f;
                    end
                    if (l > r_nhi) begin
                        r_nhi <= l;
                    end
                end
            end else if (contain) begin
                if (table_full) begin
                    r_abort <= 1'b1;
                end else begin
                    r_split <= 1'b1;
                    r_tail  <= l;
                end
            end
        end else if (i_cmd.finish) begin
            if (r_op == OP_SET) begin
                r_status <= (!r_noop && set_full) ? ST_FULL : ST_OK;
            end else begin
                r_status <= r_abort ? ST_FULL : ST_OK;
            end
        end
    end

    // Result fields, saturated to the port widths
    logic [SW-1:0] tot_w;
    logic [XW-1:0] ext_w;
    assign tot_w          = SW'(r_count);
    assign ext_w          = XW'(r_ext);
    assign o_status       = r_status;
    assign o_total_set    = (tot_w > SW'(TOTAL_SAT)) ? TOTAL_SAT : tot_w[TOTAL_W-1:0];
    assign o_extents_used = (ext_w > XW'(EXT_SAT)) ? EXT_SAT : ext_w[EXT_W-1:0];
    assign o_is_empty     = (r_ext == '0);

endmodule

// ===== src/coalescing_extent_set.sv =====
// Top level of the coalescing extent set: controller plus datapath.
// Depends on ces_pkg, ces_ctrl and ces_datapath.
//
//  channel   handshake            payload
//  command   start / busy         i_operation, i_range_start, i_range_length
//  result    o_done (one cycle)   o_status, o_total_set, o_extents_used, o_is_empty
//
// A word is taken on start; the scan then goes through the bound memories at one
// table entry per cycle, then come a commit state and a result state. An invalid
// range goes from the load straight to the result state.
// Reset empties the table at once through its valid bits. The receiver cannot
// stall; each result is presented for exactly one cycle.
module coalescing_extent_set import ces_pkg::*; #(
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_operation,
    input  logic [31:0]        i_range_start,
    input  logic [32:0]        i_range_length,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic [TOTAL_W-1:0] o_total_set,
    output logic [EXT_W-1:0]   o_extents_used,
    output logic               o_is_empty
);

    t_cmd  cmd;
    t_stat stat;

    ces_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    ces_datapath #(
        .ADDR_BITS   (ADDR_BITS),
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_operation    (i_operation),
        .i_range_start  (i_range_start),
        .i_range_length (i_range_length),
        .o_stat         (stat),
        .o_status       (o_status),
        .o_total_set    (o_total_set),
        .o_extents_used (o_extents_used),
        .o_is_empty     (o_is_empty)
    );

endmodule

// ===== dv/ces_monitor.sv =====
// Monitor for the coalescing extent set: keeps its own extent table, predicts each result
// and compares it with what the block returns. Depends on ces_pkg.
`timescale 1ns / 1ps
module ces_monitor import ces_pkg::*; #(
    parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               i_operation,
    input  logic [31:0]        i_range_start,
    input  logic [32:0]        i_range_length,
    input  logic               o_done,
    input  logic [1:0]         o_status,
    input  logic [TOTAL_W-1:0] o_total_set,
    input  logic [EXT_W-1:0]   o_extents_used,
    input  logic               o_is_empty,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        logic [1:0]         status;
        logic [TOTAL_W-1:0] total;
        logic [EXT_W-1:0]   used;
        logic               empty;
    } t_tally;

    localparam longint unsigned BLOCK_MAX = 64'hFFFF_FFFF;

    // Shadow extent table
    longint unsigned lo_tab [MAX_EXTENTS];
    longint unsigned hi_tab [MAX_EXTENTS];
    bit              live_tab [MAX_EXTENTS];
    longint unsigned blocks_set;
    int              extent_tally;

    t_tally tally_due_q [$];

    function automatic int first_free();
        for (int i = 0; i < MAX_EXTENTS; i++)
            if (!live_tab[i]) return i;
        return -1;
    endfunction

    // Remove [lo, hi] from the table; a split lands in spare
    function automatic void carve(longint unsigned lo, longint unsigned hi, int spare);
        longint unsigned f, l;
        for (int i = 0; i < MAX_EXTENTS; i++) begin
            if (!live_tab[i]) continue;
            f = lo_tab[i];
            l = hi_tab[i];
            if (l < lo || f > hi) continue;
            if (f < lo && l > hi) begin
                hi_tab[i] = lo - 1;
                if (spare >= 0) begin
                    lo_tab[spare] = hi + 1;
                    hi_tab[spare] = l;
                    live_tab[spare] = 1'b1;
                    spare = -1;
                end
            end else if (f < lo) begin
                hi_tab[i] = lo - 1;
            end else if (l > hi) begin
                lo_tab[i] = hi + 1;
            end else begin
                live_tab[i] = 1'b0;
            end
        end
    endfunction

    function automatic logic [1:0] clear_blocks(longint unsigned lo, longint unsigned hi);
        int spare;
        spare = -1;
        for (int i = 0; i < MAX_EXTENTS; i++)
            if (live_tab[i] && lo_tab[i] < lo && hi_tab[i] > hi) begin
                spare = first_free();
                if (spare < 0) return ST_FULL;
            end
        carve(lo, hi, spare);
        return ST_OK;
    endfunction

    function automatic logic [1:0] set_blocks(longint unsigned lo, longint unsigned hi);
        int li, ri, s, swallowed;
        bit touch_l, touch_r;
        li = -1; ri = -1; swallowed = 0; touch_l = 0; touch_r = 0;
        for (int i = 0; i < MAX_EXTENTS; i++) begin
            if (!live_tab[i]) continue;
            if (lo_tab[i] <= lo && hi_tab[i] >= hi) return ST_OK;
            if (lo_tab[i] >= lo && hi_tab[i] <= hi) swallowed++;
            if (lo > 0 && lo_tab[i] <= lo - 1 && hi_tab[i] >= lo - 1) touch_l = 1;
            if (hi < BLOCK_MAX && lo_tab[i] <= hi + 1 && hi_tab[i] >= hi + 1) touch_r = 1;
        end
        if (!touch_l && !touch_r && extent_tally - swallowed >= MAX_EXTENTS) return ST_FULL;
        carve(lo, hi, -1);
        for (int i = 0; i < MAX_EXTENTS; i++) begin
            if (!live_tab[i]) continue;
            if (lo > 0 && hi_tab[i] == lo - 1) li = i;
            if (hi < BLOCK_MAX && lo_tab[i] == hi + 1) ri = i;
        end
        if (li >= 0 && ri >= 0) begin
            hi_tab[li] = hi_tab[ri];
            live_tab[ri] = 1'b0;
        end else if (li >= 0) begin
            hi_tab[li] = hi;
        end else if (ri >= 0) begin
            lo_tab[ri] = lo;
        end else begin
            s = first_free();
            if (s < 0) return ST_FULL;
            lo_tab[s] = lo;
            hi_tab[s] = hi;
            live_tab[s] = 1'b1;
        end
        return ST_OK;
    endfunction

    // Apply one word to the shadow table and return the expected result
    function automatic t_tally predict_extent_op(logic op, logic [31:0] first,
                                                 logic [32:0] count);
        t_tally r;
        longint unsigned lo, hi;
        lo = 64'(first);
        if (count == 0 || longint'(count) - 1 > BLOCK_MAX - lo) begin
            r.status = ST_BAD;
        end else begin
            hi = lo + 64'(count) - 1;
            r.status = (op == OP_SET) ? set_blocks(lo, hi) : clear_blocks(lo, hi);
            blocks_set = 0;
            extent_tally = 0;
            for (int i = 0; i < MAX_EXTENTS; i++)
                if (live_tab[i]) begin
                    blocks_set += hi_tab[i] - lo_tab[i] + 1;
                    extent_tally++;
                end
        end
        r.total = TOTAL_W'(blocks_set);
        r.used  = EXT_W'(extent_tally);
        r.empty = (extent_tally == 0);
        return r;
    endfunction

    assign o_pending = tally_due_q.size();

    // Capture accepted words and returned results
    always @(posedge i_clk) begin
        t_tally got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_EXTENTS; i++) live_tab[i] = 1'b0;
            blocks_set = 0;
            extent_tally = 0;
            tally_due_q.delete();
            o_errors <= 0;
        end else begin
            if (o_done) begin
                got = '{o_status, o_total_set, o_extents_used, o_is_empty};
                if (tally_due_q.size() == 0) begin
                    $display("%0t: result with nothing expected: %p", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = tally_due_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (start && !busy)
                tally_due_q.push_back(predict_extent_op(i_operation, i_range_start,
                                                        i_range_length));
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Testbench top for the coalescing extent set: clock, reset, command stimulus and verdict.
// Depends on ces_pkg, coalescing_extent_set and ces_monitor.
`timescale 1ns / 1ps
module testbench import ces_pkg::*;;

    localparam int WATCH_LIMIT = 2000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_operation;
    logic [31:0]        i_range_start;
    logic [32:0]        i_range_length;
    logic               o_done;
    logic [1:0]         o_status;
    logic [TOTAL_W-1:0] o_total_set;
    logic [EXT_W-1:0]   o_extents_used;
    logic               o_is_empty;
    int                 fail_count;
    int                 results_due;
    int                 quiet_cycles;

    coalescing_extent_set DUT (.*);

    ces_monitor u_monitor (.*, .o_errors(fail_count), .o_pending(results_due));

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: cycles without any word moving
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Random idle time before the next word
    task automatic idle_gap();
        int pick, n;
        pick = $urandom_range(0, 99);
        n = (pick < 65) ? 0 : (pick < 95) ? $urandom_range(1, 4) : $urandom_range(20, 90);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Present one word and hold it until taken
    task automatic send_range(logic op, logic [31:0] first, logic [32:0] count);
        logic taken;
        idle_gap();
        start          <= 1'b1;
        i_operation    <= op;
        i_range_start  <= first;
        i_range_length <= count;
        // busy is settled at the falling edge; low means the next rising edge takes it
        taken = 1'b0;
        while (!taken) begin
            taken = !busy;
            @(negedge i_clk);
        end
    endtask

    initial begin
        int pick;
        quiet_cycles   = 0;
        start          = 1'b0;
        i_operation    = OP_SET;
        i_range_start  = '0;
        i_range_length = '0;
        i_rst_n        = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed corners
        send_range(OP_CLEAR, 32'd5, 33'd3);
        send_range(OP_SET, 32'd0, 33'd0);
        send_range(OP_SET, 32'hFFFF_FFFF, 33'd2);
        send_range(OP_SET, 32'd1, 33'h1_0000_0000);
        send_range(OP_SET, 32'd0, 33'h1_FFFF_FFFF);
        send_range(OP_SET, 32'd0, 33'h1_0000_0000);
        send_range(OP_SET, 32'd7, 33'd9);
        send_range(OP_CLEAR, 32'd100, 33'd50);
        send_range(OP_CLEAR, 32'd0, 33'h1_0000_0000);
        send_range(OP_SET, 32'hFFFF_FFFF, 33'd1);
        send_range(OP_SET, 32'd10, 33'd5);
        send_range(OP_SET, 32'd16, 33'd4);
        send_range(OP_SET, 32'd15, 33'd1);
        send_range(OP_SET, 32'd0, 33'd1);
        send_range(OP_CLEAR, 32'd12, 33'd2);
        send_range(OP_CLEAR, 32'd0, 33'h1_0000_0000);
        // Fill the table, then ask for a new entry and a split
        for (int k = 0; k < 31; k++) send_range(OP_SET, 32'(2 * k), 33'd1);
        send_range(OP_SET, 32'd100, 33'd3);
        send_range(OP_SET, 32'd200, 33'd1);
        send_range(OP_CLEAR, 32'd101, 33'd1);
        send_range(OP_SET, 32'd1, 33'd1);
        send_range(OP_CLEAR, 32'd0, 33'h1_0000_0000);

        // Let the outstanding results drain completely once
        start <= 1'b0;
        @(negedge i_clk);
        while (results_due != 0) @(negedge i_clk);

        // Random part: dense small window to fill and fragment the table
        for (int n = 0; n < 650; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                send_range($urandom_range(0, 3) == 0, $urandom_range(0, 160),
                           33'($urandom_range(1, 6)));
            else if (pick < 85)
                send_range(OP_CLEAR, $urandom_range(0, 160), 33'($urandom_range(20, 120)));
            else if (pick < 93)
                send_range(1'($urandom_range(0, 1)), $urandom(),
                           {1'($urandom_range(0, 1)), 32'($urandom())});
            else if (pick < 97)
                send_range(1'($urandom_range(0, 1)), 32'hFFFF_FFFF - $urandom_range(0, 8),
                           33'($urandom_range(0, 10)));
            else
                send_range(1'($urandom_range(0, 1)), $urandom_range(0, 3), 33'd0);
        end
        start <= 1'b0;

        // Wait out the last results
        while (results_due != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ces_pkg.sv
src/ces_ctrl.sv
src/ces_datapath.sv
src/coalescing_extent_set.sv
dv/ces_monitor.sv
dv/testbench.sv
